### rtl/core/mwm_pkg.sv
// Shared widths, types and reset values for the mecanum wheel mixer.
package mwm_pkg;

  // Field widths of the joystick sample, the wheel sums and the results.
  localparam int AXIS_W     = 8;
  localparam int WHEEL_W    = 10;
  localparam int MAG_W      = 9;
  localparam int LIMIT_W    = 9;
  localparam int PROD_W     = MAG_W + LIMIT_W;
  localparam int SPEED_W    = 18;
  localparam int NUM_WHEELS = 4;

  // Default number of fraction bits in the wheel speed results.
  localparam int FRAC_BITS_DEF = 8;

  // Speed limit after reset, in percent.
  localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RST = 9'd100;

  // Wheel positions in the lane arrays.
  localparam int WHEEL_FL = 0;
  localparam int WHEEL_FR = 1;
  localparam int WHEEL_BL = 2;
  localparam int WHEEL_BR = 3;

  // One wheel in sign and magnitude form.
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } wheel_t;

  // Control that travels with each transaction down the pipeline.
  typedef struct packed {
    logic valid;
    logic scale;
  } mix_ctl_t;

endpackage

### rtl/core/mwm_mixer.sv
// Front end of the mixer: wheel sums, magnitudes, largest magnitude and products.
module mwm_mixer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [mwm_pkg::AXIS_W-1:0]    fwd_axis,
  input  logic signed [mwm_pkg::AXIS_W-1:0]    strafe_axis,
  input  logic signed [mwm_pkg::AXIS_W-1:0]    turn_axis,
  input  logic        [mwm_pkg::LIMIT_W-1:0]   limit,
  output mwm_pkg::mix_ctl_t                    ctl_o,
  output mwm_pkg::wheel_t                      wheel_o [mwm_pkg::NUM_WHEELS],
  output logic        [mwm_pkg::PROD_W-1:0]    prod_o  [mwm_pkg::NUM_WHEELS],
  output logic        [mwm_pkg::MAG_W-1:0]     den_o
);

  localparam int NW = mwm_pkg::NUM_WHEELS;

  // Stage 1: signed wheel sums.
  logic                                v1_r;
  logic signed [mwm_pkg::WHEEL_W-1:0] w_r   [NW];
  logic signed [mwm_pkg::WHEEL_W-1:0] w_nxt [NW];

  // Stage 2: sign and magnitude per wheel, pairwise maxima.
  logic                              v2_r;
  mwm_pkg::wheel_t                   wh2_r   [NW];
  mwm_pkg::wheel_t                   wh2_nxt [NW];
  logic [mwm_pkg::MAG_W-1:0]         max01_r, max23_r;
  logic [mwm_pkg::MAG_W-1:0]         max01_nxt, max23_nxt;

  // Stage 3: largest magnitude and the scale decision.
  mwm_pkg::mix_ctl_t                 ctl3_r, ctl3_nxt;
  mwm_pkg::wheel_t                   wh3_r [NW];
  logic [mwm_pkg::MAG_W-1:0]         largest_r, largest_nxt;

  // Stage 4: magnitude times limit, divisor select.
  mwm_pkg::mix_ctl_t                 ctl4_r;
  mwm_pkg::wheel_t                   wh4_r   [NW];
  logic [mwm_pkg::PROD_W-1:0]        prod_r  [NW];
  logic [mwm_pkg::PROD_W-1:0]        prod_nxt[NW];
  logic [mwm_pkg::MAG_W-1:0]         den_r, den_nxt;

  // Mixing rules for the four wheels.
  always_comb begin
    logic signed [mwm_pkg::WHEEL_W-1:0] f, s, t;
    f = mwm_pkg::WHEEL_W'(fwd_axis);
    s = mwm_pkg::WHEEL_W'(strafe_axis);
    t = mwm_pkg::WHEEL_W'(turn_axis);
    w_nxt[mwm_pkg::WHEEL_FL] = f + s + t;
    w_nxt[mwm_pkg::WHEEL_FR] = f - s - t;
    w_nxt[mwm_pkg::WHEEL_BL] = f - s + t;
    w_nxt[mwm_pkg::WHEEL_BR] = f + s - t;
  end

  // Magnitudes and the first level of the maximum tree.
  always_comb begin
    logic [mwm_pkg::WHEEL_W-1:0] nw;
    for (int i = 0; i < NW; i++) begin
      nw              = mwm_pkg::WHEEL_W'(-w_r[i]);
      wh2_nxt[i].neg  = w_r[i][mwm_pkg::WHEEL_W-1];
      wh2_nxt[i].mag  = w_r[i][mwm_pkg::WHEEL_W-1] ? nw[mwm_pkg::MAG_W-1:0]
                                                   : w_r[i][mwm_pkg::MAG_W-1:0];
    end
    max01_nxt = (wh2_nxt[0].mag > wh2_nxt[1].mag) ? wh2_nxt[0].mag : wh2_nxt[1].mag;
    max23_nxt = (wh2_nxt[2].mag > wh2_nxt[3].mag) ? wh2_nxt[2].mag : wh2_nxt[3].mag;
  end

  // Largest magnitude; scaling happens only when it is strictly above the limit.
  always_comb begin
    largest_nxt    = (max01_r > max23_r) ? max01_r : max23_r;
    ctl3_nxt.valid = v2_r;
    ctl3_nxt.scale = largest_nxt > limit;
  end

  // Products for the divider; an unscaled transaction divides by one.
  always_comb begin
    for (int i = 0; i < NW; i++) begin
      prod_nxt[i] = mwm_pkg::PROD_W'(wh3_r[i].mag) * mwm_pkg::PROD_W'(limit);
    end
    den_nxt = ctl3_r.scale ? largest_r : mwm_pkg::MAG_W'(1);
  end

  // Valid bits of the four stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      ctl3_r <= '0;
      ctl4_r <= '0;
    end else if (en) begin
      v1_r   <= in_valid;
      v2_r   <= v1_r;
      ctl3_r <= ctl3_nxt;
      ctl4_r <= ctl3_r;
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NW; i++) begin
        w_r[i]    <= w_nxt[i];
        wh2_r[i]  <= wh2_nxt[i];
        wh3_r[i]  <= wh2_r[i];
        wh4_r[i]  <= wh3_r[i];
        prod_r[i] <= prod_nxt[i];
      end
      max01_r   <= max01_nxt;
      max23_r   <= max23_nxt;
      largest_r <= largest_nxt;
      den_r     <= den_nxt;
    end
  end

  assign ctl_o   = ctl4_r;
  assign wheel_o = wh4_r;
  assign prod_o  = prod_r;
  assign den_o   = den_r;

endmodule

### rtl/core/mwm_div_lane.sv
// Pipelined restoring divider lane, one quotient bit per stage, with side data.
module mwm_div_lane #(
  parameter int DEN_W  = 9,
  parameter int QUO_W  = 17,
  parameter int SIDE_W = 10
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [DEN_W+QUO_W-1:0]   num,
  input  logic [DEN_W-1:0]         den,
  input  logic [SIDE_W-1:0]        side_i,
  output logic [QUO_W-1:0]         quo,
  output logic [SIDE_W-1:0]        side_o
);

  // The upper DEN_W bits of the numerator are known to be below the divisor.
  localparam int NUM_W = DEN_W + QUO_W;

  logic [DEN_W-1:0]  rem_r  [QUO_W];
  logic [QUO_W-1:0]  lo_r   [QUO_W];
  logic [QUO_W-1:0]  quo_r  [QUO_W];
  logic [DEN_W-1:0]  den_r  [QUO_W];
  logic [SIDE_W-1:0] side_r [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [DEN_W-1:0]  rem_i;
    logic [QUO_W-1:0]  lo_i;
    logic [QUO_W-1:0]  quo_i;
    logic [DEN_W-1:0]  den_i;
    logic [SIDE_W-1:0] side_i_k;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    // The first stage takes the operands straight from the ports.
    if (k == 0) begin : g_first
      assign rem_i    = num[NUM_W-1 -: DEN_W];
      assign lo_i     = num[QUO_W-1:0];
      assign quo_i    = '0;
      assign den_i    = den;
      assign side_i_k = side_i;
    end else begin : g_next
      assign rem_i    = rem_r[k-1];
      assign lo_i     = lo_r[k-1];
      assign quo_i    = quo_r[k-1];
      assign den_i    = den_r[k-1];
      assign side_i_k = side_r[k-1];
    end

    // Bring down one numerator bit and try to subtract the divisor.
    assign trial = {rem_i, lo_i[QUO_W-1]};
    assign diff  = trial - {1'b0, den_i};
    assign ge    = trial >= {1'b0, den_i};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        lo_r[k]   <= {lo_i[QUO_W-2:0], 1'b0};
        quo_r[k]  <= {quo_i[QUO_W-2:0], ge};
        den_r[k]  <= den_i;
        side_r[k] <= side_i_k;
      end
    end
  end

  assign quo    = quo_r[QUO_W-1];
  assign side_o = side_r[QUO_W-1];

endmodule

### rtl/core/mecanum_wheel_mixer_unit.sv
// Top level of the mecanum wheel mixer with speed normalization.
// Pipeline: 14 + FRAC_BITS register stages from input acceptance to out_valid.
// Throughput: one transaction per cycle unless a stalled output holds the pipeline;
// the divider has one stage per quotient bit.
// A stalled output freezes the whole pipeline and raises in_stall for that cycle.
// Reset clears all pipeline valid bits and sets the speed limit to 100 percent.
module mecanum_wheel_mixer_unit #(
  parameter int FRAC_BITS = mwm_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input channel.
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [mwm_pkg::AXIS_W-1:0]   in_fwd_axis,
  input  logic signed [mwm_pkg::AXIS_W-1:0]   in_strafe_axis,
  input  logic signed [mwm_pkg::AXIS_W-1:0]   in_turn_axis,
  // Result channel.
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [mwm_pkg::SPEED_W-1:0]  out_front_left_speed,
  output logic signed [mwm_pkg::SPEED_W-1:0]  out_front_right_speed,
  output logic signed [mwm_pkg::SPEED_W-1:0]  out_back_left_speed,
  output logic signed [mwm_pkg::SPEED_W-1:0]  out_back_right_speed,
  output logic                                out_was_scaled,
  // Configuration port.
  input  logic                                cfg_wr_en,
  input  logic        [mwm_pkg::LIMIT_W-1:0]  cfg_wr_data
);

  localparam int NW     = mwm_pkg::NUM_WHEELS;
  localparam int DEN_W  = mwm_pkg::MAG_W;
  localparam int QUO_W  = mwm_pkg::LIMIT_W + FRAC_BITS;
  localparam int NUM_W  = mwm_pkg::PROD_W + FRAC_BITS;
  localparam int SIDE_W = $bits(mwm_pkg::wheel_t);
  localparam int EXT_W  = (QUO_W > mwm_pkg::SPEED_W) ? QUO_W : mwm_pkg::SPEED_W;

  logic                          adv;
  logic [mwm_pkg::LIMIT_W-1:0]   speed_limit_r;

  mwm_pkg::mix_ctl_t             mix_ctl;
  mwm_pkg::wheel_t               mix_wheel [NW];
  logic [mwm_pkg::PROD_W-1:0]    mix_prod  [NW];
  logic [DEN_W-1:0]              mix_den;

  logic [NUM_W-1:0]              div_num   [NW];
  logic [QUO_W-1:0]              div_quo   [NW];
  logic [SIDE_W-1:0]             div_side  [NW];
  mwm_pkg::mix_ctl_t             ctl_r     [QUO_W];

  logic                          out_valid_r;
  logic                          scaled_r, scaled_nxt;
  logic [mwm_pkg::SPEED_W-1:0]   speed_r   [NW];
  logic [mwm_pkg::SPEED_W-1:0]   speed_nxt [NW];

  // The pipeline moves whenever the output register is free or being taken.
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // Speed limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_limit_r <= mwm_pkg::SPEED_LIMIT_RST;
    end else if (cfg_wr_en) begin
      speed_limit_r <= cfg_wr_data;
    end
  end

  // Mixing, magnitudes, largest magnitude and products.
  mwm_mixer u_mixer (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (adv),
    .in_valid    (in_valid),
    .fwd_axis    (in_fwd_axis),
    .strafe_axis (in_strafe_axis),
    .turn_axis   (in_turn_axis),
    .limit       (speed_limit_r),
    .ctl_o       (mix_ctl),
    .wheel_o     (mix_wheel),
    .prod_o      (mix_prod),
    .den_o       (mix_den)
  );

  // One divider lane per wheel; all lanes share the largest magnitude as divisor.
  for (genvar i = 0; i < NW; i++) begin : g_lane
    assign div_num[i] = mix_ctl.scale ? (NUM_W'(mix_prod[i]) << FRAC_BITS) : '0;

    mwm_div_lane #(
      .DEN_W  (DEN_W),
      .QUO_W  (QUO_W),
      .SIDE_W (SIDE_W)
    ) u_div (
      .clk    (clk),
      .en     (adv),
      .num    (div_num[i]),
      .den    (mix_den),
      .side_i (mix_wheel[i]),
      .quo    (div_quo[i]),
      .side_o (div_side[i])
    );
  end

  // Control shift line alongside the divider stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QUO_W; k++) begin
        ctl_r[k] <= '0;
      end
    end else if (adv) begin
      ctl_r[0] <= mix_ctl;
      for (int k = 1; k < QUO_W; k++) begin
        ctl_r[k] <= ctl_r[k-1];
      end
    end
  end

  // Pick scaled or plain magnitude, restore the sign and wrap to the field width.
  always_comb begin
    mwm_pkg::wheel_t    wh;
    logic [EXT_W-1:0]   sel;
    for (int i = 0; i < NW; i++) begin
      wh  = mwm_pkg::wheel_t'(div_side[i]);
      sel = ctl_r[QUO_W-1].scale ? EXT_W'(div_quo[i]) : (EXT_W'(wh.mag) << FRAC_BITS);
      if (wh.neg) begin
        sel = -sel;
      end
      speed_nxt[i] = sel[mwm_pkg::SPEED_W-1:0];
    end
    scaled_nxt = ctl_r[QUO_W-1].scale;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ctl_r[QUO_W-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      speed_r  <= speed_nxt;
      scaled_r <= scaled_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_front_left_speed  = $signed(speed_r[mwm_pkg::WHEEL_FL]);
  assign out_front_right_speed = $signed(speed_r[mwm_pkg::WHEEL_FR]);
  assign out_back_left_speed   = $signed(speed_r[mwm_pkg::WHEEL_BL]);
  assign out_back_right_speed  = $signed(speed_r[mwm_pkg::WHEEL_BR]);
  assign out_was_scaled        = scaled_r;

`ifndef SYNTHESIS
  // A scaled transaction divides by a largest magnitude above the limit.
  a_scale_den: assert property (@(posedge clk) disable iff (!rst_n)
    mix_ctl.valid && mix_ctl.scale |-> mix_den > speed_limit_r)
    else $error("scaled transaction with divisor not above the speed limit");

  // An unscaled transaction runs the divider with a divisor of one.
  a_plain_den: assert property (@(posedge clk) disable iff (!rst_n)
    mix_ctl.valid && !mix_ctl.scale |-> mix_den == DEN_W'(1))
    else $error("unscaled transaction with divisor other than one");

  // A scaled wheel never exceeds the limit in fixed point.
  a_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r[QUO_W-1].valid && ctl_r[QUO_W-1].scale |->
      div_quo[0] <= (QUO_W'(speed_limit_r) << FRAC_BITS) &&
      div_quo[1] <= (QUO_W'(speed_limit_r) << FRAC_BITS) &&
      div_quo[2] <= (QUO_W'(speed_limit_r) << FRAC_BITS) &&
      div_quo[3] <= (QUO_W'(speed_limit_r) << FRAC_BITS))
    else $error("scaled wheel above the speed limit");
`endif

endmodule
